### src/oaht_pkg.sv
// Package for the open-addressing hash table: sizes, operation and slot
// status codes, the slot entry layout, the FSM encoding and probe arithmetic.
// No dependencies.
package oaht_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int SIZE_W      = SLOT_W + 1;
	localparam int VALUE_WIDTH = 32;
	localparam int KEY_W       = 31;
	localparam int KIND_W      = 2;

	// hashing: (HASH_MUL*key + HASH_ADD) mod HASH_MOD, with
	// HASH_MUL = HASH_MOD - 6 and HASH_ADD = HASH_MOD - 9
	localparam int HASH_W   = 24;
	localparam logic [HASH_W-1:0] HASH_MOD = 24'd8888899;
	localparam int FOLD_W   = HASH_W + 3;
	localparam int SHIFT_W  = KEY_W + 1;
	localparam int BITS_PER_STEP = 4;
	localparam int HASH_STEPS = SHIFT_W / BITS_PER_STEP;
	localparam int DIV_STEPS  = HASH_W / BITS_PER_STEP;
	localparam int STEP_W     = $clog2(HASH_STEPS);

	// request kinds
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// slot status codes
	localparam logic [1:0] ST_EMPTY = 2'd0;
	localparam logic [1:0] ST_LIVE  = 2'd1;
	localparam logic [1:0] ST_DEL   = 2'd2;

	typedef struct packed {
		logic [1:0]             status;
		logic [KEY_W-1:0]       key;
		logic [VALUE_WIDTH-1:0] value;
	} slot_entry_t;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_HASH  = 7'b0000010,
		S_FOLD  = 7'b0000100,
		S_DIV   = 7'b0001000,
		S_ISSUE = 7'b0010000,
		S_PROBE = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	// (a + b) mod m for a, b below m
	function automatic logic [SLOT_W-1:0] add_mod(input logic [SLOT_W-1:0] a,
			input logic [SLOT_W-1:0] b, input logic [SIZE_W-1:0] m);
		logic [SIZE_W-1:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= m) begin
			sum = sum - m;
		end
		return sum[SLOT_W-1:0];
	endfunction

	// 6 mod m, m from 1 up
	function automatic logic [SLOT_W-1:0] six_mod(input logic [SIZE_W-1:0] m);
		logic [SLOT_W-1:0] r;
		case (m) inside
			9'd1, 9'd2, 9'd3, 9'd6: r = '0;
			9'd4: r = SLOT_W'(2);
			9'd5: r = SLOT_W'(1);
			default: r = SLOT_W'(6);
		endcase
		return r;
	endfunction

	// 2 mod m, m from 1 up
	function automatic logic [SLOT_W-1:0] two_mod(input logic [SIZE_W-1:0] m);
		logic [SLOT_W-1:0] r;
		case (m) inside
			9'd1, 9'd2: r = '0;
			default: r = SLOT_W'(2);
		endcase
		return r;
	endfunction

endpackage

### src/open_addressing_hash_table.sv
// channel   signals                                       beat when
// cfg       cfg_wr_en, cfg_wr_data                        cfg_wr_en high
// in        in_valid, in_stall, kind, key, payload        in_valid & !in_stall
// out       out_valid, out_stall, success, slot_index,    out_valid & !out_stall
//           found_payload, entry_total
// From accept to result a request goes through these steps: the key is reduced
// mod 8888899 four bits at a time, the multiplier is folded in, the hash is reduced
// mod table_size four bits at a time, then one slot is probed per cycle through the
// slot memory. Requests that fail before probing go straight to the result.
// Reset empties the table through per-slot valid flops; no clearing pass.
// A result waiting in the output register does not block the next accept.
// Open-addressing hash table top level; uses oaht_pkg.
module open_addressing_hash_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [oaht_pkg::SIZE_W-1:0]      cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [oaht_pkg::KIND_W-1:0]      kind,
	input  logic [oaht_pkg::KEY_W-1:0]       key,
	input  logic [oaht_pkg::VALUE_WIDTH-1:0] payload,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             success,
	output logic [oaht_pkg::SLOT_W-1:0]      slot_index,
	output logic [oaht_pkg::VALUE_WIDTH-1:0] found_payload,
	output logic [oaht_pkg::SIZE_W-1:0]      entry_total
);
	import oaht_pkg::*;

	// control state
	state_t                 state_q;
	logic [SIZE_W-1:0]      size_q;
	logic [SIZE_W-1:0]      live_q;
	logic [STEP_W-1:0]      step_q;
	logic                   out_vld_q;
	logic [TABLE_DEPTH-1:0] vld_q;

	// request and datapath registers
	logic [KIND_W-1:0]      kind_q;
	logic [KEY_W-1:0]       key_q;
	logic [VALUE_WIDTH-1:0] pay_q;
	logic [HASH_W-1:0]      acc_q;
	logic [SHIFT_W-1:0]     sh_q;
	logic [SLOT_W-1:0]      j_q;
	logic [SLOT_W-1:0]      e_q;
	logic [SLOT_W-1:0]      s_q;
	logic [SIZE_W-1:0]      pcnt_q;
	logic                   res_ok_q;
	logic [SLOT_W-1:0]      res_idx_q;
	logic [VALUE_WIDTH-1:0] res_pay_q;
	logic [SIZE_W-1:0]      res_tot_q;
	logic                   out_ok_q;
	logic [SLOT_W-1:0]      out_idx_q;
	logic [VALUE_WIDTH-1:0] out_pay_q;
	logic [SIZE_W-1:0]      out_tot_q;

	// slot memory
	slot_entry_t            mem [TABLE_DEPTH];
	slot_entry_t            rd_entry_s1;
	logic                   rd_vld_s1;

	// combinational
	logic                   accept_in;
	logic                   early_fail;
	logic                   load_out;
	logic [HASH_W-1:0]      hacc;
	logic [HASH_W:0]        hsum;
	logic [FOLD_W-1:0]      fold_t;
	logic [FOLD_W-1:0]      fold_r;
	logic                   fold_hit;
	logic [HASH_W-1:0]      home_h;
	logic [SIZE_W-1:0]      dacc;
	logic [SIZE_W:0]        dsum;
	logic                   is_ins;
	logic                   slot_live;
	logic                   slot_empty;
	logic                   last_probe;
	logic                   hit;
	logic                   miss;
	logic                   wr_en;
	slot_entry_t            wr_data;
	logic [SLOT_W-1:0]      e_n;
	logic [SLOT_W-1:0]      s_n;
	logic [SLOT_W-1:0]      j_n;
	logic [SLOT_W-1:0]      rd_addr;
	logic [SIZE_W-1:0]      live_n;

	assign in_stall      = (state_q != S_IDLE);
	assign accept_in     = in_valid && (state_q == S_IDLE);
	assign load_out      = (state_q == S_DONE) && (!out_vld_q || !out_stall);
	assign out_valid     = out_vld_q;
	assign success       = out_ok_q;
	assign slot_index    = out_idx_q;
	assign found_payload = out_pay_q;
	assign entry_total   = out_tot_q;

	// requests that fail without probing
	always_comb begin
		early_fail = 1'b0;
		if (kind == KIND_UNUSED) begin
			early_fail = 1'b1;
		end else if (kind == KIND_INSERT) begin
			early_fail = (live_q >= size_q);
		end else begin
			early_fail = (live_q == '0);
		end
	end

	// key mod 8888899, four key bits per cycle, msb first
	always_comb begin
		hacc = acc_q;
		hsum = '0;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			hsum = {hacc, sh_q[SHIFT_W-1-b]};
			if (hsum >= {1'b0, HASH_MOD}) begin
				hsum = hsum - {1'b0, HASH_MOD};
			end
			hacc = hsum[HASH_W-1:0];
		end
	end

	// hash = -(6*r + 9) mod 8888899
	always_comb begin
		fold_t   = {1'b0, acc_q, 2'b0} + {2'b0, acc_q, 1'b0} + FOLD_W'(9);
		fold_r   = fold_t;
		fold_hit = 1'b0;
		for (int m = 6; m >= 1; m--) begin
			if (!fold_hit && fold_t >= FOLD_W'(m) * FOLD_W'(HASH_MOD)) begin
				fold_r   = fold_t - FOLD_W'(m) * FOLD_W'(HASH_MOD);
				fold_hit = 1'b1;
			end
		end
		home_h = (fold_r == '0) ? '0 : HASH_MOD - fold_r[HASH_W-1:0];
	end

	// hash mod table_size, four bits per cycle into j_q
	always_comb begin
		dacc = {1'b0, j_q};
		dsum = '0;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			dsum = {dacc, sh_q[SHIFT_W-1-b]};
			if (dsum >= {1'b0, size_q}) begin
				dsum = dsum - {1'b0, size_q};
			end
			dacc = dsum[SIZE_W-1:0];
		end
	end

	// probe decision on the slot read last cycle
	always_comb begin
		is_ins     = (kind_q == KIND_INSERT);
		slot_live  = rd_vld_s1 && (rd_entry_s1.status == ST_LIVE);
		slot_empty = !rd_vld_s1 || (rd_entry_s1.status == ST_EMPTY);
		last_probe = ((pcnt_q + SIZE_W'(1)) == size_q);
		if (is_ins) begin
			hit  = !slot_live;
			miss = !hit && last_probe;
		end else begin
			hit  = slot_live && (rd_entry_s1.key == key_q);
			miss = !hit && (slot_empty || last_probe);
		end
		wr_en = (state_q == S_PROBE) && hit && (is_ins || kind_q == KIND_DELETE);
		if (is_ins) begin
			wr_data = '{status: ST_LIVE, key: key_q, value: pay_q};
		end else begin
			wr_data = '{status: ST_DEL, key: rd_entry_s1.key, value: rd_entry_s1.value};
		end
		live_n = is_ins ? live_q + SIZE_W'(1) : live_q - SIZE_W'(1);
	end

	// next probe: step 5i+3i^2 kept as running sums with increment 6i+2
	always_comb begin
		e_n     = add_mod(e_q, six_mod(size_q), size_q);
		s_n     = add_mod(s_q, e_n, size_q);
		j_n     = add_mod(j_q, s_n, size_q);
		rd_addr = (state_q == S_PROBE) ? j_n : j_q;
	end

	// slot memory, one read and one write port
	always_ff @(posedge clk) begin
		rd_entry_s1 <= mem[rd_addr];
		rd_vld_s1   <= vld_q[rd_addr];
		if (wr_en) begin
			mem[j_q] <= wr_data;
		end
	end

	// control: fsm, table size, live count, valid bits, output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			size_q    <= SIZE_W'(TABLE_DEPTH);
			live_q    <= '0;
			step_q    <= '0;
			out_vld_q <= 1'b0;
			vld_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_wr_data == '0) begin
					size_q <= SIZE_W'(1);
				end else if (cfg_wr_data > SIZE_W'(TABLE_DEPTH)) begin
					size_q <= SIZE_W'(TABLE_DEPTH);
				end else begin
					size_q <= cfg_wr_data;
				end
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			if (wr_en) begin
				vld_q[j_q] <= 1'b1;
				live_q     <= live_n;
			end
			unique case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (accept_in) begin
						state_q <= early_fail ? S_DONE : S_HASH;
					end
				end
				S_HASH: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(HASH_STEPS - 1)) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (hit || miss) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath and result registers
	always_ff @(posedge clk) begin
		if (accept_in) begin
			kind_q    <= kind;
			key_q     <= key;
			pay_q     <= payload;
			acc_q     <= '0;
			sh_q      <= {1'b0, key};
			res_ok_q  <= 1'b0;
			res_idx_q <= '0;
			res_pay_q <= '0;
			res_tot_q <= live_q;
		end
		if (state_q == S_HASH) begin
			acc_q <= hacc;
			sh_q  <= sh_q << BITS_PER_STEP;
		end
		if (state_q == S_FOLD) begin
			sh_q <= {home_h, {(SHIFT_W - HASH_W){1'b0}}};
			j_q  <= '0;
		end
		if (state_q == S_DIV) begin
			j_q  <= dacc[SLOT_W-1:0];
			sh_q <= sh_q << BITS_PER_STEP;
		end
		if (state_q == S_ISSUE) begin
			e_q    <= two_mod(size_q);
			s_q    <= '0;
			pcnt_q <= '0;
		end
		if (state_q == S_PROBE) begin
			if (hit) begin
				res_ok_q  <= 1'b1;
				res_idx_q <= j_q;
				res_pay_q <= is_ins ? '0 : rd_entry_s1.value;
				res_tot_q <= (is_ins || kind_q == KIND_DELETE) ? live_n : live_q;
			end else if (miss) begin
				res_ok_q  <= 1'b0;
				res_idx_q <= '0;
				res_pay_q <= '0;
				res_tot_q <= live_q;
			end else begin
				j_q    <= j_n;
				e_q    <= e_n;
				s_q    <= s_n;
				pcnt_q <= pcnt_q + SIZE_W'(1);
			end
		end
		if (load_out) begin
			out_ok_q  <= res_ok_q;
			out_idx_q <= res_idx_q;
			out_pay_q <= res_pay_q;
			out_tot_q <= res_tot_q;
		end
	end

	// checks
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> state_q == S_IDLE)
		else $error("input beat taken outside idle");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= SIZE_W'(TABLE_DEPTH))
		else $error("live count above table depth");

	a_live_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (live_q == $past(live_q) || live_q == $past(live_q) + SIZE_W'(1)
			|| live_q == $past(live_q) - SIZE_W'(1)))
		else $error("live count moved by more than one");

	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PROBE |-> {1'b0, j_q} < size_q)
		else $error("probe slot outside table size");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !success |-> slot_index == '0 && found_payload == '0)
		else $error("failed result carries slot or payload");

endmodule
